// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; users provide i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/bra_pkg.sv =====
// Package for the bitmap run allocator: transfer types, codes, control structs.
// No dependencies.
`default_nettype none

package bra_pkg;

    localparam int unsigned MAX_BITS_DEF   = 1024;
    localparam logic [10:0] CFG_SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_MARK_USED = 2'd0,
        OP_MARK_FREE = 2'd1,
        OP_FIND_FREE = 2'd2,
        OP_FIND_USED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RS_OK    = 2'd0,
        RS_RANGE = 2'd1,
        RS_NORUN = 2'd2
    } t_rstat;

    typedef struct packed {
        t_op         op;
        logic [9:0]  position;
        logic [10:0] count;
    } t_req;

    typedef struct packed {
        t_rstat     status;
        logic [9:0] index;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_MARK_RD,
        S_MARK_WR,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic mark_rd;
        logic mark_wr;
        logic scan;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_find;
        logic find_trivial;
        logic mark_skip;
        logic mark_last;
        logic scan_done;
        logic out_free;
    } t_ctl_sts;

    // Size register value to bits in use: whole bytes, capped at the store size.
    function automatic logic [10:0] eff_size(logic [10:0] sz, int unsigned max_bits);
        logic [10:0] s;
        s = {sz[10:3], 3'b000};
        if (32'(s) > max_bits) begin
            s = 11'(max_bits);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bra_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bra_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bra_ctrl.sv =====
// Controller FSM for the bitmap run allocator: sequences clear, mark and scan.
// Depends on bra_pkg.
`default_nettype none

module bra_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire bra_pkg::t_ctl_sts i_sts,
    output bra_pkg::t_ctl_cmd      o_cmd
);
    import bra_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_find) begin
                    n_state = i_sts.find_trivial ? S_RESULT : S_SCAN;
                end else begin
                    n_state = i_sts.mark_skip ? S_RESULT : S_MARK_RD;
                end
            end
            S_MARK_RD: begin
                o_cmd.mark_rd = 1'b1;
                n_state       = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                n_state       = i_sts.mark_last ? S_RESULT : S_MARK_RD;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bra_dpath.sv =====
// Datapath for the bitmap run allocator: size register, bitmap RAM,
// byte mask merge, run scanner and result register. Depends on bra_pkg, bra_ram.
`default_nettype none

module bra_dpath #(
    parameter int unsigned MAX_BITS = bra_pkg::MAX_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [10:0]       i_cfg_wdata,
    input  wire bra_pkg::t_req     i_in_data,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output bra_pkg::t_rsp          o_out_data,
    input  wire bra_pkg::t_ctl_cmd i_cmd,
    output bra_pkg::t_ctl_sts      o_sts
);
    import bra_pkg::*;

    localparam int DEPTH = MAX_BITS / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [10:0]   r_eff;
    t_op           r_op;
    logic [10:0]   r_pos;
    logic [10:0]   r_cnt;
    logic [10:0]   r_end;
    logic [7:0]    r_ptr;
    logic [7:0]    r_dptr;
    logic          r_dv;
    logic [10:0]   r_run;
    logic [10:0]   r_start;
    logic          r_found;
    logic          r_exhaust;
    logic [AW-1:0] r_clr_addr;

    logic [11:0]   n_end_sum;
    logic [10:0]   n_end;
    logic [7:0]    byte_cnt;
    logic [7:0]    last_mark;
    logic          want;
    logic          issue;
    logic [7:0]    rdata;
    logic [7:0]    mask;
    logic [7:0]    merged;
    logic [10:0]   sc_run;
    logic [10:0]   sc_start;
    logic          sc_found;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;

    assign want      = (r_op == OP_FIND_USED);
    assign byte_cnt  = r_eff[10:3];
    assign last_mark = 8'((r_end - 11'd1) >> 3);
    assign issue     = i_cmd.scan && (r_ptr < byte_cnt);

    assign n_end_sum = {1'b0, i_in_data.count} + {2'b00, i_in_data.position};
    assign n_end     = (n_end_sum > {1'b0, r_eff}) ? r_eff : n_end_sum[10:0];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            mask[j] = ({r_ptr, 3'(j)} >= r_pos) && ({r_ptr, 3'(j)} < r_end);
        end
        merged = (r_op == OP_MARK_USED) ? (rdata | mask) : (rdata & ~mask);
    end

    // One byte of the first-fit scan, lowest bit first.
    always_comb begin
        sc_run   = r_run;
        sc_start = r_start;
        sc_found = 1'b0;
        for (int j = 0; j < 8; j++) begin
            if (!sc_found) begin
                if (rdata[j] == want) begin
                    if (sc_run == 11'd0) begin
                        sc_start = {r_dptr, 3'(j)};
                    end
                    sc_run = sc_run + 11'd1;
                    if (sc_run == r_cnt) begin
                        sc_found = 1'b1;
                    end
                end else begin
                    sc_run = 11'd0;
                end
            end
        end
    end

    assign ram_we    = i_cmd.clr_wr || i_cmd.mark_wr;
    assign ram_waddr = i_cmd.clr_wr ? r_clr_addr : AW'(r_ptr);
    assign ram_wdata = i_cmd.clr_wr ? 8'h00 : merged;

    bra_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.mark_rd || issue),
        .i_raddr (AW'(r_ptr)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff       <= eff_size(CFG_SIZE_RESET, MAX_BITS);
            r_clr_addr  <= '0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_exhaust   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eff <= eff_size(i_cfg_wdata, MAX_BITS);
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.load) begin
                r_dv      <= 1'b0;
                r_found   <= 1'b0;
                r_exhaust <= 1'b0;
            end else begin
                r_dv <= issue;
                if (r_dv && !r_found && !r_exhaust) begin
                    r_found <= sc_found;
                    if (!sc_found && (r_dptr == byte_cnt - 8'd1)) begin
                        r_exhaust <= 1'b1;
                    end
                end
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_data.op;
            r_pos   <= {1'b0, i_in_data.position};
            r_cnt   <= i_in_data.count;
            r_end   <= n_end;
            r_run   <= '0;
            r_start <= '0;
            r_ptr   <= (i_in_data.op == OP_FIND_FREE || i_in_data.op == OP_FIND_USED)
                       ? 8'd0 : {1'b0, i_in_data.position[9:3]};
        end else begin
            if (i_cmd.mark_wr || issue) begin
                r_ptr <= r_ptr + 8'd1;
            end
            if (issue) begin
                r_dptr <= r_ptr;
            end
            if (r_dv && !r_found && !r_exhaust) begin
                r_run   <= sc_run;
                r_start <= sc_start;
            end
        end
        if (i_cmd.out_load) begin
            if (r_op == OP_FIND_FREE || r_op == OP_FIND_USED) begin
                o_out_data.status <= r_found ? RS_OK : RS_NORUN;
                o_out_data.index  <= r_found ? r_start[9:0] : 10'd0;
            end else begin
                o_out_data.status <= (r_pos >= r_eff) ? RS_RANGE : RS_OK;
                o_out_data.index  <= 10'd0;
            end
        end
    end

    always_comb begin
        o_sts              = '0;
        o_sts.clr_last     = (r_clr_addr == AW'(DEPTH - 1));
        o_sts.is_find      = (r_op == OP_FIND_FREE) || (r_op == OP_FIND_USED);
        o_sts.find_trivial = (r_cnt == 11'd0) || (r_eff == 11'd0);
        o_sts.mark_skip    = (r_pos >= r_eff) || (r_end <= r_pos);
        o_sts.mark_last    = (r_ptr == last_mark);
        o_sts.scan_done    = r_found || r_exhaust;
        o_sts.out_free     = !o_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_run_allocator_top.sv =====
// Top level of the bitmap run allocator: controller plus datapath.
// Depends on bra_pkg, bra_ctrl, bra_dpath, bra_ram.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+------------------------
//   request  | i_in_valid  | o_in_stall  | i_in_data  (t_req)
//   result   | o_out_valid | i_out_stall | o_out_data (t_rsp)
//   config   | i_cfg_we    | -           | i_cfg_wdata (size_in_use)
//
// After reset the bitmap RAM is cleared one byte a cycle, all MAX_BITS/8 bytes,
// requests stalled meanwhile.
// Find: one RAM byte read per cycle.
// Mark: each byte touched is read, then written back merged.
// Out of range, zero count and empty size: no RAM access, straight to the result.
// One request at a time; a request is taken while the previous result waits.
`default_nettype none

module bitmap_run_allocator_top #(
    parameter int unsigned MAX_BITS = bra_pkg::MAX_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [10:0]   i_cfg_wdata,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bra_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output bra_pkg::t_rsp      o_out_data
);
    import bra_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    bra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bra_dpath #(
        .MAX_BITS (MAX_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

// ===== rtl/bra_checker.sv =====
// Port-level checks for the bitmap run allocator, bound to the top level.
// Depends on bra_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bra_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire bra_pkg::t_rsp o_out_data
);
    import bra_pkg::*;

    `BRA_ASSERT_ALWAYS(a_clear_stalls, !i_rst_n |=> o_in_stall, "request taken during clear")
    `BRA_ASSERT(a_one_at_a_time, i_in_valid && !o_in_stall |=> o_in_stall, "second request taken")
    `BRA_ASSERT(a_index_zero, o_out_valid && o_out_data.status != RS_OK |-> o_out_data.index == 10'd0, "index set without run")
    `BRA_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

bind bitmap_run_allocator_top bra_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
